@@ rtl/utf8_japanese_string_checker_defines.svh @@
// Assertion macros for the UTF-8 Japanese string checker.
// Used by the checker module only; needs clk and arst_n in scope.
`ifndef UTF8_JAPANESE_STRING_CHECKER_DEFINES_SVH
`define UTF8_JAPANESE_STRING_CHECKER_DEFINES_SVH

// plain property, disabled during reset
`define U8JC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define U8JC_ASSERT_IMPL(lbl, ante, cons, msg) \
	`U8JC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ rtl/u8jc_pkg.sv @@
// Package for the UTF-8 Japanese string checker.
// Error codes, limits, range and length helpers; no dependencies.
package u8jc_pkg;

	localparam int CP_W = 21;

	typedef logic [CP_W-1:0] cp_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_BAD_LEAD = 3'd1,
		ERR_BAD_CONT = 3'd2,
		ERR_INCOMPL  = 3'd3,
		ERR_OVERLONG = 3'd4,
		ERR_RANGE    = 3'd5
	} err_t;

	localparam cp_t CP_MAX     = 21'h10FFFF;
	localparam cp_t ASCII_LO   = 21'h000020;
	localparam cp_t ASCII_HI   = 21'h00007E;
	localparam cp_t CJK_SYM_LO = 21'h003000;
	localparam cp_t CJK_SYM_HI = 21'h0030FF;
	localparam cp_t HW_KANA_LO = 21'h00FF65;
	localparam cp_t HW_KANA_HI = 21'h00FF9F;
	localparam cp_t FW_FORM_LO = 21'h00FF01;
	localparam cp_t FW_FORM_HI = 21'h00FF5E;
	localparam cp_t KANJI_LO   = 21'h004E00;
	localparam cp_t KANJI_HI   = 21'h009FFF;

	// tdata layout of a result
	localparam int OUT_TDATA_W = 32;

	function automatic logic is_japanese(input cp_t cp);
		return (cp >= CJK_SYM_LO && cp <= CJK_SYM_HI) ||
		       (cp >= HW_KANA_LO && cp <= HW_KANA_HI) ||
		       (cp >= FW_FORM_LO && cp <= FW_FORM_HI) ||
		       (cp >= KANJI_LO && cp <= KANJI_HI);
	endfunction

	// smallest legal code point for a given number of continuation bytes
	function automatic cp_t min_for_len(input logic [1:0] conts);
		cp_t r;
		case (conts)
			2'd1: r = 21'h000080;
			2'd2: r = 21'h000800;
			2'd3: r = 21'h010000;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/utf8_japanese_string_checker.sv @@
// UTF-8 Japanese string checker: decodes one byte per transaction and gives a verdict per string.
// Each byte's result is registered; throughput: 1 byte per cycle while s_axis_tready is high.
// Decode and classify are combinational between the string state and the result register.
// s_axis_tready stays high while the result register is empty or being taken.
// arst_n clears string state, allow_ascii and the result valid flag.
// Depends on u8jc_pkg.
module utf8_japanese_string_checker import u8jc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,          // allow_ascii
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,       // [7:0] data_byte
	input  logic       s_axis_tuser,       // [0] has_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata, // [20:0] codepoint, [21] cp_japanese,
	                                             // [24:22] error_code, [25] verdict
	output logic       m_axis_tuser,       // [0] cp_ready
	output logic       m_axis_tlast        // string_done
);

	logic       allow_ascii_q;
	cp_t        accum_q, accum_n;
	logic [1:0] bytes_left_q, bytes_left_n;
	logic [1:0] seq_len_q, seq_len_n;
	logic       failed_q, failed_n;
	logic       seen_q, seen_n;

	logic       accept;
	logic       complete;
	logic       ready_c, jp_c, verdict_c;
	cp_t        cp_c;
	err_t       err_c;
	logic [7:0] b;

	logic       out_valid_q;
	cp_t        out_cp_q;
	logic       out_jp_q, out_ready_q, out_done_q, out_verdict_q;
	err_t       out_err_q;

	assign b             = s_axis_tdata;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		accum_n      = accum_q;
		bytes_left_n = bytes_left_q;
		seq_len_n    = seq_len_q;
		failed_n     = failed_q;
		seen_n       = seen_q;
		complete     = 1'b0;
		ready_c      = 1'b0;
		cp_c         = '0;
		jp_c         = 1'b0;
		err_c        = ERR_NONE;
		verdict_c    = 1'b0;
		if (s_axis_tuser && !failed_q) begin
			seen_n = 1'b1;
			if (bytes_left_q == 2'd0) begin
				if (!b[7]) begin
					accum_n   = {13'd0, b};
					seq_len_n = 2'd0;
					complete  = 1'b1;
				end else if (b[7:5] == 3'b110) begin
					accum_n      = {16'd0, b[4:0]};
					bytes_left_n = 2'd1;
					seq_len_n    = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					accum_n      = {17'd0, b[3:0]};
					bytes_left_n = 2'd2;
					seq_len_n    = 2'd2;
				end else if (b[7:3] == 5'b11110) begin
					accum_n      = {18'd0, b[2:0]};
					bytes_left_n = 2'd3;
					seq_len_n    = 2'd3;
				end else begin
					err_c    = ERR_BAD_LEAD;
					failed_n = 1'b1;
				end
			end else if (b[7:6] != 2'b10) begin
				err_c        = ERR_BAD_CONT;
				failed_n     = 1'b1;
				bytes_left_n = 2'd0;
			end else begin
				accum_n      = {accum_q[CP_W-7:0], b[5:0]};
				bytes_left_n = bytes_left_q - 2'd1;
				complete     = (bytes_left_q == 2'd1);
			end
			if (complete) begin
				if (accum_n < min_for_len(seq_len_n)) begin
					err_c    = ERR_OVERLONG;
					failed_n = 1'b1;
				end else if (accum_n > CP_MAX) begin
					err_c    = ERR_RANGE;
					failed_n = 1'b1;
				end else begin
					ready_c = 1'b1;
					cp_c    = accum_n;
					jp_c    = is_japanese(accum_n);
					if (!(jp_c || (allow_ascii_q && accum_n >= ASCII_LO &&
					               accum_n <= ASCII_HI)))
						failed_n = 1'b1;
				end
			end
		end
		if (s_axis_tlast) begin
			if (!failed_n && bytes_left_n != 2'd0) begin
				err_c    = ERR_INCOMPL;
				failed_n = 1'b1;
			end
			verdict_c    = seen_n && !failed_n;
			accum_n      = '0;
			bytes_left_n = 2'd0;
			seq_len_n    = 2'd0;
			failed_n     = 1'b0;
			seen_n       = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_ascii_q <= 1'b0;
		end else if (cfg_we) begin
			allow_ascii_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q      <= '0;
			bytes_left_q <= 2'd0;
			seq_len_q    <= 2'd0;
			failed_q     <= 1'b0;
			seen_q       <= 1'b0;
		end else if (accept) begin
			accum_q      <= accum_n;
			bytes_left_q <= bytes_left_n;
			seq_len_q    <= seq_len_n;
			failed_q     <= failed_n;
			seen_q       <= seen_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_cp_q      <= cp_c;
			out_jp_q      <= jp_c;
			out_err_q     <= err_c;
			out_ready_q   <= ready_c;
			out_done_q    <= s_axis_tlast;
			out_verdict_q <= verdict_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-CP_W-5){1'b0}}, out_verdict_q, out_err_q,
	                        out_jp_q, out_cp_q};
	assign m_axis_tuser  = out_ready_q;
	assign m_axis_tlast  = out_done_q;

endmodule

@@ rtl/u8jc_checker.sv @@
// Port-level assertions for utf8_japanese_string_checker, bound to the top level.
// Depends on u8jc_pkg and utf8_japanese_string_checker_defines.svh.
`include "utf8_japanese_string_checker_defines.svh"
module u8jc_checker import u8jc_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser,
	input logic                   m_axis_tlast
);

	logic [2:0] err;
	logic       vrd;

	assign err = m_axis_tdata[CP_W+3:CP_W+1];
	assign vrd = m_axis_tdata[CP_W+4];

	`U8JC_ASSERT_IMPL(a_err_code_legal, m_axis_tvalid, err <= ERR_RANGE, "illegal error code")
	`U8JC_ASSERT_IMPL(a_cp_no_err, m_axis_tvalid && m_axis_tuser, err == ERR_NONE, "code point with error")
	`U8JC_ASSERT_IMPL(a_verdict_at_end, m_axis_tvalid && vrd, m_axis_tlast && err == ERR_NONE, "verdict off string end")
	`U8JC_ASSERT_IMPL(a_incompl_at_end, m_axis_tvalid && err == ERR_INCOMPL, m_axis_tlast, "incomplete before end")
	`U8JC_ASSERT(a_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "result dropped")

endmodule

bind utf8_japanese_string_checker u8jc_checker u_u8jc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

@@ tb/utf8_jp_result_checker.sv @@
// Result checker for the UTF-8 Japanese string checker: watches the config port and both
// streams, works out each expected result and compares it with what the block gives.
// Depends on u8jc_pkg.
`timescale 1ns / 1ps

module utf8_jp_result_checker import u8jc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,    // [7:0] data_byte
	input  logic                   s_axis_tuser,    // [0] has_byte
	input  logic                   s_axis_tlast,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,    // [20:0] codepoint, [21] cp_japanese,
	                                                // [24:22] error_code, [25] verdict
	input  logic                   m_axis_tuser,    // [0] cp_ready
	input  logic                   m_axis_tlast,    // string_done
	output int                     fail_count,
	output int                     outstanding
);

	typedef struct {
		logic cp_ready;
		cp_t  codepoint;
		logic japanese;
		err_t err;
		logic done;
		logic verdict;
	} char_result_t;

	char_result_t expected_results[$];
	int           mismatches = 0;

	// decoder state mirrored from the block
	logic       allow_ascii;
	cp_t        accum;
	logic [1:0] bytes_left;
	logic [1:0] seq_length;
	logic       failed;
	logic       seen_byte;

	function automatic logic in_jp_range(input cp_t cp);
		return (cp >= CJK_SYM_LO && cp <= CJK_SYM_HI) ||
		       (cp >= HW_KANA_LO && cp <= HW_KANA_HI) ||
		       (cp >= FW_FORM_LO && cp <= FW_FORM_HI) ||
		       (cp >= KANJI_LO && cp <= KANJI_HI);
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic has, input logic lst,
			output char_result_t r);
		logic complete;
		cp_t  shortest;
		complete    = 1'b0;
		r.cp_ready  = 1'b0;
		r.codepoint = '0;
		r.japanese  = 1'b0;
		r.err       = ERR_NONE;
		r.done      = 1'b0;
		r.verdict   = 1'b0;
		if (has && !failed) begin
			seen_byte = 1'b1;
			if (bytes_left == 2'd0) begin
				if (!b[7]) begin
					accum = {13'd0, b};
					seq_length = 2'd0;
					complete = 1'b1;
				end else if (b[7:5] == 3'b110) begin
					accum = {16'd0, b[4:0]};
					bytes_left = 2'd1;
					seq_length = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					accum = {17'd0, b[3:0]};
					bytes_left = 2'd2;
					seq_length = 2'd2;
				end else if (b[7:3] == 5'b11110) begin
					accum = {18'd0, b[2:0]};
					bytes_left = 2'd3;
					seq_length = 2'd3;
				end else begin
					r.err = ERR_BAD_LEAD;
					failed = 1'b1;
				end
			end else if (b[7:6] != 2'b10) begin
				r.err = ERR_BAD_CONT;
				failed = 1'b1;
				bytes_left = 2'd0;
			end else begin
				accum = {accum[14:0], b[5:0]};
				bytes_left = bytes_left - 2'd1;
				complete = (bytes_left == 2'd0);
			end
			if (complete) begin
				case (seq_length)
					2'd1: shortest = 21'h000080;
					2'd2: shortest = 21'h000800;
					2'd3: shortest = 21'h010000;
					default: shortest = '0;
				endcase
				if (accum < shortest) begin
					r.err = ERR_OVERLONG;
					failed = 1'b1;
				end else if (accum > CP_MAX) begin
					r.err = ERR_RANGE;
					failed = 1'b1;
				end else begin
					r.cp_ready = 1'b1;
					r.codepoint = accum;
					r.japanese = in_jp_range(accum);
					if (!(r.japanese || (allow_ascii && accum >= ASCII_LO && accum <= ASCII_HI)))
						failed = 1'b1;
				end
			end
		end
		if (lst) begin
			if (!failed && bytes_left != 2'd0) begin
				r.err = ERR_INCOMPL;
				failed = 1'b1;
			end
			r.done = 1'b1;
			r.verdict = seen_byte && !failed;
			accum = '0;
			bytes_left = 2'd0;
			seq_length = 2'd0;
			failed = 1'b0;
			seen_byte = 1'b0;
		end
	endtask

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		char_result_t want;
		char_result_t next_exp;
		if (!arst_n) begin
			allow_ascii = 1'b0;
			accum = '0;
			bytes_left = 2'd0;
			seq_length = 2'd0;
			failed = 1'b0;
			seen_byte = 1'b0;
			expected_results.delete();
			fail_count <= mismatches;
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with no expected result pending");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("cp_ready", want.cp_ready, m_axis_tuser);
					check_field("codepoint", want.codepoint, m_axis_tdata[20:0]);
					check_field("cp_japanese", want.japanese, m_axis_tdata[21]);
					check_field("error_code", want.err, m_axis_tdata[24:22]);
					check_field("verdict", want.verdict, m_axis_tdata[25]);
					check_field("string_done", want.done, m_axis_tlast);
					check_field("tdata_pad", '0, m_axis_tdata[OUT_TDATA_W-1:26]);
				end
			end
			if (cfg_we)
				allow_ascii = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast, next_exp);
				expected_results.push_back(next_exp);
			end
			fail_count <= mismatches;
			outstanding <= expected_results.size();
		end
	end

endmodule

@@ tb/tb_utf8_japanese_string_checker.sv @@
// Testbench top for the UTF-8 Japanese string checker: directed and random UTF-8 strings,
// allow_ascii changes between phases, random idling on both streams.
// Depends on u8jc_pkg, utf8_japanese_string_checker and utf8_jp_result_checker.
`timescale 1ns / 1ps

module tb_utf8_japanese_string_checker import u8jc_pkg::*; ();

	localparam int ITEM_TARGET = 1850;
	localparam int PHASE_ITEMS = 200;
	localparam int CYCLE_LIMIT = 400000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic                   cfg_wdata = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = 8'd0;     // [7:0] data_byte
	logic                   s_axis_tuser = 1'b0;     // [0] has_byte
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;            // [20:0] codepoint, [21] cp_japanese,
	                                                 // [24:22] error_code, [25] verdict
	logic                   m_axis_tuser;            // [0] cp_ready
	logic                   m_axis_tlast;            // string_done

	int fail_count;
	int outstanding;
	int cycle_count = 0;
	int items_sent = 0;
	bit sender_gaps = 1'b1;
	bit sink_stalls = 1'b1;

	// pending string: {has_byte, data_byte} per transaction
	logic [8:0] text_q[$];

	utf8_japanese_string_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	utf8_jp_result_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		m_axis_tready <= !sink_stalls || ($urandom_range(99) >= 37);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_item(input logic [7:0] b, input logic has, input logic lst);
		while (sender_gaps && $urandom_range(99) < 37) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= has;
		s_axis_tlast  <= lst;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_text();
		int k;
		for (k = 0; k < text_q.size(); k++)
			send_item(text_q[k][7:0], text_q[k][8], k == text_q.size() - 1);
		items_sent += text_q.size();
		text_q.delete();
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_allow_ascii(input logic v);
		drain_results();
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic int min_conts(input cp_t cp);
		return (cp < 21'h80) ? 0 : (cp < 21'h800) ? 1 : (cp < 21'h10000) ? 2 : 3;
	endfunction

	// encode cp with the given number of continuation bytes (more than needed = overlong)
	task automatic push_enc(input cp_t cp, input int conts);
		logic [7:0] lead;
		int k;
		case (conts)
			0: lead = {1'b0, cp[6:0]};
			1: lead = {3'b110, cp[10:6]};
			2: lead = {4'b1110, cp[15:12]};
			default: lead = {5'b11110, cp[20:18]};
		endcase
		text_q.push_back({1'b1, lead});
		for (k = conts - 1; k >= 0; k--)
			text_q.push_back({1'b1, 2'b10, cp[6*k +: 6]});
	endtask

	function automatic cp_t rand_cp_of_conts(input int conts);
		case (conts)
			1: return cp_t'($urandom_range(21'h80, 21'h7FF));
			2: return cp_t'($urandom_range(21'h800, 21'hFFFF));
			default: return cp_t'($urandom_range(21'h10000, CP_MAX));
		endcase
	endfunction

	task automatic add_random_char(input bit clean);
		int pick;
		int conts;
		int corner;
		cp_t lo;
		cp_t hi;
		cp_t cp;
		logic [8:0] dropped;
		pick = clean ? $urandom_range(74) : $urandom_range(99);
		case ($urandom_range(3))
			0: begin lo = CJK_SYM_LO; hi = CJK_SYM_HI; end
			1: begin lo = HW_KANA_LO; hi = HW_KANA_HI; end
			2: begin lo = FW_FORM_LO; hi = FW_FORM_HI; end
			default: begin lo = KANJI_LO; hi = KANJI_HI; end
		endcase
		corner = $urandom_range(9);
		if (pick < 50) begin
			cp = (corner == 0) ? lo : (corner == 1) ? hi : cp_t'($urandom_range(lo, hi));
			push_enc(cp, min_conts(cp));
		end else if (pick < 65) begin
			cp = cp_t'($urandom_range(0, 127));
			push_enc(cp, 0);
		end else if (pick < 75) begin
			if (corner < 3)
				cp = (corner == 0) ? lo - 21'd1 : hi + 21'd1;
			else
				cp = rand_cp_of_conts($urandom_range(1, 3));
			push_enc(cp, min_conts(cp));
		end else if (pick < 80) begin
			conts = $urandom_range(1, 3);
			cp = cp_t'($urandom_range(0, (conts == 1) ? 21'h7F : (conts == 2) ? 21'h7FF : 21'hFFFF));
			push_enc(cp, conts);
		end else if (pick < 84) begin
			push_enc(cp_t'($urandom_range(CP_MAX + 21'd1, 21'h1FFFFF)), 3);
		end else if (pick < 90) begin
			conts = $urandom_range(1, 3);
			push_enc(rand_cp_of_conts(conts), conts);
			repeat ($urandom_range(1, conts))
				dropped = text_q.pop_back();
		end else if (pick < 95) begin
			text_q.push_back({1'b1, 8'($urandom)});
		end else begin
			text_q.push_back({1'b0, 8'($urandom)});
		end
	endtask

	task automatic add_random_string();
		int nchars;
		int k;
		bit clean;
		if ($urandom_range(99) < 5) begin
			text_q.push_back({1'b0, 8'($urandom)});
		end else begin
			clean = $urandom_range(99) < 70;
			nchars = ($urandom_range(99) < 5) ? $urandom_range(7, 20) : $urandom_range(1, 6);
			for (k = 0; k < nchars; k++)
				add_random_char(clean);
			if ($urandom_range(99) < 10)
				text_q.push_back({1'b0, 8'($urandom)});
		end
	endtask

	initial begin
		int phase;
		int phase_end;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty string
		text_q.push_back({1'b0, 8'h00});
		send_text();
		// hiragana, last flag on the completing byte
		push_enc(21'h3042, 2);
		send_text();
		// bare item mid-string, then a kanji
		text_q.push_back({1'b0, 8'hFF});
		push_enc(KANJI_HI, 2);
		send_text();
		// zero byte
		text_q.push_back({1'b1, 8'h00});
		send_text();
		// bad lead, then a byte that must be ignored
		text_q.push_back({1'b1, 8'hFF});
		text_q.push_back({1'b1, 8'h41});
		send_text();
		// non-continuation inside a sequence
		text_q.push_back({1'b1, 8'hE3});
		text_q.push_back({1'b1, 8'h41});
		send_text();
		// sequence cut off by last
		text_q.push_back({1'b1, 8'hE3});
		text_q.push_back({1'b1, 8'h81});
		send_text();
		// overlong two-byte NUL
		push_enc(21'h0, 1);
		send_text();
		// above U+10FFFF
		push_enc(21'h110000, 3);
		send_text();
		// printable ASCII with ascii allowed
		set_allow_ascii(1'b1);
		push_enc(ASCII_LO + 21'h21, 0);
		push_enc(ASCII_HI, 0);
		send_text();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			set_allow_ascii(phase[0]);
			sender_gaps = (phase != 3);
			sink_stalls = (phase != 3);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
				add_random_string();
				send_text();
			end
			phase++;
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
